[hdl/audio_packet_frame_parser_top_defines.svh]
`ifndef AUDIO_PACKET_FRAME_PARSER_TOP_DEFINES_SVH
`define AUDIO_PACKET_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define APFP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame parser check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define APFP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame parser check failed");

`endif

[hdl/apfp_pkg.sv]
`timescale 1ns / 1ps

package apfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned SIZE_W = 11;
   localparam int unsigned CNT_W = 6;

   localparam int unsigned MAX_FRAME_BYTES = 1275;
   localparam logic [BYTE_W-1:0] SIZE_ESCAPE = 8'd252;
   localparam logic [BYTE_W-1:0] PAD_CHAIN = 8'd255;
   localparam logic [BYTE_W-1:0] PAD_CHAIN_BYTES = 8'd254;
   localparam int unsigned PAD_FLAG_BIT = 6;
   localparam int unsigned VBR_FLAG_BIT = 7;

   typedef enum logic [1:0] {
      FC_ONE,
      FC_TWO_EQUAL,
      FC_TWO_CODED,
      FC_MULTI
   } fcode_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_C2_LO,
      PH_C2_HI,
      PH_C3_COUNT,
      PH_C3_PAD,
      PH_C3_LO,
      PH_C3_HI
   } phase_type;

   typedef enum logic [2:0] {
      CT_IDLE,
      CT_DIV,
      CT_FILL,
      CT_LASTW,
      CT_READ,
      CT_EMIT,
      CT_FAIL
   } ctl_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_FAIL,
      ACT_FINISH,
      ACT_SPLIT,
      ACT_DIVIDE
   } act_type;

   // Largest frame count that keeps a packet within 120 ms at 48 kHz
   // (5760 samples), given the frame duration coded in the TOC byte.
   function automatic logic [CNT_W-1:0] max_count(input logic [BYTE_W-1:0] toc_b);
      logic [CNT_W-1:0] res;
      if (toc_b[7]) begin
         unique case (toc_b[4:3])
            2'd0: res = 6'd48;
            2'd1: res = 6'd24;
            2'd2: res = 6'd12;
            default: res = 6'd6;
         endcase
      end else if (toc_b[6:5] == 2'b11) begin
         res = toc_b[3] ? 6'd6 : 6'd12;
      end else begin
         unique case (toc_b[4:3])
            2'd0: res = 6'd12;
            2'd1: res = 6'd6;
            2'd2: res = 6'd3;
            default: res = 6'd2;
         endcase
      end
      return res;
   endfunction

endpackage

[hdl/apfp_if.sv]
`timescale 1ns / 1ps

interface apfp_req_if;
   logic valid;
   logic ready;
   logic [apfp_pkg::BYTE_W-1:0] data_byte;
   logic packet_start;
   logic [apfp_pkg::LEN_W-1:0] packet_len;

   modport source (output valid, data_byte, packet_start, packet_len, input ready);
   modport sink (input valid, data_byte, packet_start, packet_len, output ready);
endinterface

interface apfp_rsp_if;
   logic valid;
   logic ready;
   logic status;
   logic [apfp_pkg::BYTE_W-1:0] toc;
   logic [apfp_pkg::CNT_W-1:0] frame_count;
   logic [apfp_pkg::CNT_W-1:0] frame_index;
   logic [apfp_pkg::LEN_W-1:0] frame_offset;
   logic [apfp_pkg::SIZE_W-1:0] frame_size;
   logic [apfp_pkg::LEN_W-1:0] header_len;
   logic last_record;

   modport source (output valid, status, toc, frame_count, frame_index, frame_offset,
                   frame_size, header_len, last_record, input ready);
   modport sink (input valid, status, toc, frame_count, frame_index, frame_offset,
                 frame_size, header_len, last_record, output ready);
endinterface

[hdl/apfp_ram.sv]
`timescale 1ns / 1ps

module apfp_ram #(
   parameter int unsigned WIDTH = 11,
   parameter int unsigned DEPTH = 48
) (
   input  logic clock,
   input  logic we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/apfp_div.sv]
`timescale 1ns / 1ps

module apfp_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [apfp_pkg::LEN_W-1:0] dividend,
   input  logic [apfp_pkg::CNT_W-1:0] divisor,
   output logic done,
   output logic [apfp_pkg::LEN_W-1:0] quotient,
   output logic [apfp_pkg::CNT_W-1:0] remainder
);

   localparam int unsigned LW = apfp_pkg::LEN_W;
   localparam int unsigned CW = apfp_pkg::CNT_W;
   localparam int unsigned STEP_W = $clog2(LW + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic done_ff, done_in;
   logic [LW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] dsr_ff, dsr_in;
   logic [CW:0] trial;
   logic [CW:0] diff;

   // Restoring division, one quotient bit per cycle. The partial remainder
   // stays below the divisor, so the top bit of diff is a clean borrow flag.
   always_comb begin
      trial = {rem_ff, quo_ff[LW-1]};
      diff = trial - {1'b0, dsr_ff};
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         step_in = STEP_W'(LW);
      end else if (step_ff != '0) begin
         rem_in = diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
         quo_in = {quo_ff[LW-2:0], ~diff[CW]};
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

[hdl/audio_packet_frame_parser_top.sv]
`timescale 1ns / 1ps
// Header bytes are taken one per cycle; payload bytes after the header are taken and dropped.
// The first record follows the byte that ends the header through the last-size write and a size
// memory read; equal frame sizes are filled in first, and a code 3 equal split waits on the divider.
// Each record then takes a size memory read and is presented until taken; no byte is taken meanwhile.
// Synchronous active-high reset returns the sequencer and parse phase to idle.
// The frame size memory is not cleared; every entry read was written for the current packet.

module audio_packet_frame_parser_top #(
   parameter int unsigned MAX_FRAMES = 48,
   parameter int unsigned MAX_PACKET_BYTES = 65535
) (
   input logic clock,
   input logic reset,
   apfp_req_if.sink req_ch,
   apfp_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned LW = apfp_pkg::LEN_W;
   localparam int unsigned SW = apfp_pkg::SIZE_W;
   localparam int unsigned CW = apfp_pkg::CNT_W;
   localparam int unsigned BW = apfp_pkg::BYTE_W;

   apfp_pkg::ctl_type ctl_ff, ctl_in;
   apfp_pkg::phase_type phase_ff, phase_in;
   apfp_pkg::act_type act;
   apfp_pkg::fcode_type fcode;

   logic [BW-1:0] toc_ff, toc_in;
   logic [CW-1:0] nfr_ff, nfr_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] hdr_ff, hdr_in;
   logic [BW-1:0] low_ff, low_in;
   logic [CW-1:0] sidx_ff, sidx_in;
   logic [LW-1:0] avail_ff, avail_in;
   // Two's complement byte budget: bytes left minus padding, and later
   // minus the coded sizes already taken.
   logic [LW+1:0] budget_ff, budget_in;
   logic [SW-1:0] fin_ff, fin_in;
   logic [SW-1:0] fill_ff, fill_in;
   logic [CW-1:0] ctr_ff, ctr_in;
   logic [LW-1:0] off_ff, off_in;

   logic [BW-1:0] data_b;
   logic [LW-1:0] plen_dec;
   logic [LW-1:0] rem_dec;
   logic [LW-1:0] avail_dec;
   logic [SW-1:0] big_size;
   logic [SW-1:0] sz_take;
   logic [SW-1:0] c2_size;
   logic [LW:0] c2_left;
   logic [LW+1:0] pad_budget;
   logic [LW+1:0] take_budget;
   logic [LW+1:0] ap_budget;
   logic [LW:0] fin_cand;
   logic do_after;
   logic last_idx;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [SW-1:0] ram_wdata;
   logic ram_re;
   logic [SW-1:0] ram_q;

   logic div_start;
   logic div_done;
   logic [LW-1:0] div_q;
   logic [CW-1:0] div_r;

   apfp_ram #(
      .WIDTH(SW),
      .DEPTH(MAX_FRAMES)
   ) u_size_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ctr_ff[IDX_W-1:0]),
      .rdata(ram_q)
   );

   apfp_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(ap_budget[LW-1:0]),
      .divisor(nfr_in),
      .done(div_done),
      .quotient(div_q),
      .remainder(div_r)
   );

   assign data_b = req_ch.data_byte;
   assign fcode = apfp_pkg::fcode_type'(req_ch.data_byte[1:0]);
   assign plen_dec = req_ch.packet_len - LW'(1);
   assign rem_dec = rem_ff - LW'(1);
   assign avail_dec = avail_ff - LW'(1);
   assign big_size = SW'({data_b, 2'b00}) + SW'(low_ff);
   assign sz_take = (phase_ff == apfp_pkg::PH_C3_HI) ? big_size : SW'(data_b);
   assign c2_size = (phase_ff == apfp_pkg::PH_C2_HI) ? big_size : SW'(data_b);
   assign c2_left = {1'b0, rem_dec} - (LW + 1)'(c2_size);
   assign take_budget = budget_ff - (LW + 2)'(1) - (LW + 2)'(sz_take);
   assign pad_budget = budget_ff[LW+1] ? budget_ff :
                       budget_ff - (LW + 2)'(1) -
                       (LW + 2)'((data_b == apfp_pkg::PAD_CHAIN) ?
                                 apfp_pkg::PAD_CHAIN_BYTES : data_b);
   assign last_idx = (ctr_ff == nfr_ff - CW'(1));

   always_comb begin
      ctl_in = ctl_ff;
      phase_in = phase_ff;
      toc_in = toc_ff;
      nfr_in = nfr_ff;
      rem_in = rem_ff;
      hdr_in = hdr_ff;
      low_in = low_ff;
      sidx_in = sidx_ff;
      avail_in = avail_ff;
      budget_in = budget_ff;
      fin_in = fin_ff;
      fill_in = fill_ff;
      ctr_in = ctr_ff;
      off_in = off_ff;
      act = apfp_pkg::ACT_NONE;
      fin_cand = '0;
      do_after = 1'b0;
      ap_budget = '0;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re = 1'b0;
      div_start = 1'b0;

      unique case (ctl_ff)
         apfp_pkg::CT_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.packet_start) begin
                  toc_in = data_b;
                  hdr_in = LW'(1);
                  low_in = '0;
                  sidx_in = '0;
                  nfr_in = '0;
                  phase_in = apfp_pkg::PH_IDLE;
                  if (req_ch.packet_len == '0 ||
                      (LW + 1)'(req_ch.packet_len) > (LW + 1)'(MAX_PACKET_BYTES)) begin
                     act = apfp_pkg::ACT_FAIL;
                  end else begin
                     rem_in = plen_dec;
                     unique case (fcode)
                        apfp_pkg::FC_ONE: begin
                           nfr_in = CW'(1);
                           act = apfp_pkg::ACT_FINISH;
                           fin_cand = (LW + 1)'(plen_dec);
                        end
                        apfp_pkg::FC_TWO_EQUAL: begin
                           nfr_in = CW'(2);
                           fin_cand = (LW + 1)'(plen_dec[LW-1:1]);
                           act = plen_dec[0] ? apfp_pkg::ACT_FAIL : apfp_pkg::ACT_SPLIT;
                        end
                        apfp_pkg::FC_TWO_CODED: begin
                           nfr_in = CW'(2);
                           phase_in = apfp_pkg::PH_C2_LO;
                           if (plen_dec == '0) act = apfp_pkg::ACT_FAIL;
                        end
                        apfp_pkg::FC_MULTI: begin
                           phase_in = apfp_pkg::PH_C3_COUNT;
                           if (plen_dec == '0) act = apfp_pkg::ACT_FAIL;
                        end
                     endcase
                  end
               end else if (phase_ff == apfp_pkg::PH_IDLE || rem_ff == '0) begin
                  phase_in = apfp_pkg::PH_IDLE;
               end else begin
                  rem_in = rem_dec;
                  hdr_in = hdr_ff + LW'(1);
                  unique case (phase_ff)
                     apfp_pkg::PH_C2_LO, apfp_pkg::PH_C2_HI: begin
                        if (phase_ff == apfp_pkg::PH_C2_LO &&
                            data_b >= apfp_pkg::SIZE_ESCAPE) begin
                           low_in = data_b;
                           phase_in = apfp_pkg::PH_C2_HI;
                           if (rem_dec == '0) act = apfp_pkg::ACT_FAIL;
                        end else if (c2_left[LW]) begin
                           act = apfp_pkg::ACT_FAIL;
                        end else begin
                           ram_we = 1'b1;
                           ram_wdata = c2_size;
                           act = apfp_pkg::ACT_FINISH;
                           fin_cand = c2_left;
                        end
                     end
                     apfp_pkg::PH_C3_COUNT: begin
                        if (data_b[CW-1:0] == '0 ||
                            (CW + 1)'(data_b[CW-1:0]) > (CW + 1)'(MAX_FRAMES) ||
                            data_b[CW-1:0] > apfp_pkg::max_count(toc_ff)) begin
                           act = apfp_pkg::ACT_FAIL;
                        end else begin
                           nfr_in = data_b[CW-1:0];
                           low_in = data_b;
                           budget_in = (LW + 2)'(rem_dec);
                           if (data_b[apfp_pkg::PAD_FLAG_BIT]) begin
                              phase_in = apfp_pkg::PH_C3_PAD;
                              if (rem_dec == '0) act = apfp_pkg::ACT_FAIL;
                           end else begin
                              do_after = 1'b1;
                              ap_budget = (LW + 2)'(rem_dec);
                           end
                        end
                     end
                     apfp_pkg::PH_C3_PAD: begin
                        budget_in = pad_budget;
                        if (data_b == apfp_pkg::PAD_CHAIN) begin
                           if (rem_dec == '0) act = apfp_pkg::ACT_FAIL;
                        end else begin
                           do_after = 1'b1;
                           ap_budget = pad_budget;
                        end
                     end
                     apfp_pkg::PH_C3_LO, apfp_pkg::PH_C3_HI: begin
                        avail_in = avail_dec;
                        if (phase_ff == apfp_pkg::PH_C3_LO &&
                            data_b >= apfp_pkg::SIZE_ESCAPE) begin
                           low_in = data_b;
                           phase_in = apfp_pkg::PH_C3_HI;
                           budget_in = budget_ff - (LW + 2)'(1);
                           if (avail_dec == '0) act = apfp_pkg::ACT_FAIL;
                        end else if (LW'(sz_take) > avail_dec) begin
                           act = apfp_pkg::ACT_FAIL;
                        end else begin
                           ram_we = 1'b1;
                           ram_waddr = sidx_ff[IDX_W-1:0];
                           ram_wdata = sz_take;
                           sidx_in = sidx_ff + CW'(1);
                           budget_in = take_budget;
                           // The last frame's size is implied once all but one are coded.
                           if ((CW + 1)'(sidx_ff) + (CW + 1)'(2) >= (CW + 1)'(nfr_ff)) begin
                              if (take_budget[LW+1]) begin
                                 act = apfp_pkg::ACT_FAIL;
                              end else begin
                                 act = apfp_pkg::ACT_FINISH;
                                 fin_cand = take_budget[LW:0];
                              end
                           end else begin
                              phase_in = apfp_pkg::PH_C3_LO;
                              if (avail_dec == '0) act = apfp_pkg::ACT_FAIL;
                           end
                        end
                     end
                     default: begin
                        phase_in = apfp_pkg::PH_IDLE;
                     end
                  endcase
               end

               // Padding is known: choose coded sizes or an equal split.
               if (do_after) begin
                  if (ap_budget[LW+1]) begin
                     act = apfp_pkg::ACT_FAIL;
                  end else if (low_in[apfp_pkg::VBR_FLAG_BIT]) begin
                     if (nfr_in == CW'(1)) begin
                        act = apfp_pkg::ACT_FINISH;
                        fin_cand = ap_budget[LW:0];
                     end else begin
                        phase_in = apfp_pkg::PH_C3_LO;
                        avail_in = ap_budget[LW-1:0];
                        budget_in = ap_budget;
                        sidx_in = '0;
                        if (ap_budget == '0) act = apfp_pkg::ACT_FAIL;
                     end
                  end else begin
                     act = apfp_pkg::ACT_DIVIDE;
                  end
               end

               if ((act == apfp_pkg::ACT_FINISH || act == apfp_pkg::ACT_SPLIT) &&
                   (fin_cand > (LW + 1)'(apfp_pkg::MAX_FRAME_BYTES) || nfr_in == '0 ||
                    (CW + 1)'(nfr_in) > (CW + 1)'(MAX_FRAMES))) begin
                  act = apfp_pkg::ACT_FAIL;
               end

               unique case (act)
                  apfp_pkg::ACT_NONE: begin
                  end
                  apfp_pkg::ACT_FAIL: begin
                     phase_in = apfp_pkg::PH_IDLE;
                     ctl_in = apfp_pkg::CT_FAIL;
                  end
                  apfp_pkg::ACT_FINISH: begin
                     phase_in = apfp_pkg::PH_IDLE;
                     fin_in = fin_cand[SW-1:0];
                     ctl_in = apfp_pkg::CT_LASTW;
                  end
                  apfp_pkg::ACT_SPLIT: begin
                     phase_in = apfp_pkg::PH_IDLE;
                     fin_in = fin_cand[SW-1:0];
                     fill_in = fin_cand[SW-1:0];
                     ctr_in = '0;
                     ctl_in = apfp_pkg::CT_FILL;
                  end
                  apfp_pkg::ACT_DIVIDE: begin
                     phase_in = apfp_pkg::PH_IDLE;
                     div_start = 1'b1;
                     ctl_in = apfp_pkg::CT_DIV;
                  end
               endcase
            end
         end

         apfp_pkg::CT_DIV: begin
            if (div_done) begin
               if (div_r != '0 || div_q > LW'(apfp_pkg::MAX_FRAME_BYTES)) begin
                  ctl_in = apfp_pkg::CT_FAIL;
               end else begin
                  fin_in = div_q[SW-1:0];
                  fill_in = div_q[SW-1:0];
                  ctr_in = '0;
                  ctl_in = (nfr_ff > CW'(1)) ? apfp_pkg::CT_FILL : apfp_pkg::CT_LASTW;
               end
            end
         end

         apfp_pkg::CT_FILL: begin
            ram_we = 1'b1;
            ram_waddr = ctr_ff[IDX_W-1:0];
            ram_wdata = fill_ff;
            ctr_in = ctr_ff + CW'(1);
            if ((CW + 1)'(ctr_ff) + (CW + 1)'(2) >= (CW + 1)'(nfr_ff)) begin
               ctl_in = apfp_pkg::CT_LASTW;
            end
         end

         apfp_pkg::CT_LASTW: begin
            ram_we = 1'b1;
            ram_waddr = IDX_W'(nfr_ff - CW'(1));
            ram_wdata = fin_ff;
            ctr_in = '0;
            off_in = hdr_ff;
            ctl_in = apfp_pkg::CT_READ;
         end

         apfp_pkg::CT_READ: begin
            ram_re = 1'b1;
            ctl_in = apfp_pkg::CT_EMIT;
         end

         apfp_pkg::CT_EMIT: begin
            if (rsp_ch.ready) begin
               off_in = off_ff + LW'(ram_q);
               if (last_idx) begin
                  ctl_in = apfp_pkg::CT_IDLE;
               end else begin
                  ctr_in = ctr_ff + CW'(1);
                  ctl_in = apfp_pkg::CT_READ;
               end
            end
         end

         apfp_pkg::CT_FAIL: begin
            if (rsp_ch.ready) begin
               ctl_in = apfp_pkg::CT_IDLE;
            end
         end

         default: begin
            ctl_in = apfp_pkg::CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= apfp_pkg::CT_IDLE;
         phase_ff <= apfp_pkg::PH_IDLE;
      end else begin
         ctl_ff <= ctl_in;
         phase_ff <= phase_in;
      end
      toc_ff <= toc_in;
      nfr_ff <= nfr_in;
      rem_ff <= rem_in;
      hdr_ff <= hdr_in;
      low_ff <= low_in;
      sidx_ff <= sidx_in;
      avail_ff <= avail_in;
      budget_ff <= budget_in;
      fin_ff <= fin_in;
      fill_ff <= fill_in;
      ctr_ff <= ctr_in;
      off_ff <= off_in;
   end

   assign req_ch.ready = (ctl_ff == apfp_pkg::CT_IDLE);

   assign rsp_ch.valid = (ctl_ff == apfp_pkg::CT_EMIT) || (ctl_ff == apfp_pkg::CT_FAIL);
   assign rsp_ch.status = (ctl_ff == apfp_pkg::CT_FAIL);
   assign rsp_ch.toc = toc_ff;
   assign rsp_ch.frame_count = rsp_ch.status ? '0 : nfr_ff;
   assign rsp_ch.frame_index = rsp_ch.status ? '0 : ctr_ff;
   assign rsp_ch.frame_offset = rsp_ch.status ? '0 : off_ff;
   assign rsp_ch.frame_size = rsp_ch.status ? '0 : ram_q;
   assign rsp_ch.header_len = rsp_ch.status ? '0 : hdr_ff;
   assign rsp_ch.last_record = rsp_ch.status | last_idx;

endmodule

[hdl/apfp_checker.sv]
`timescale 1ns / 1ps
`include "audio_packet_frame_parser_top_defines.svh"

module apfp_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_status,
   input logic [5:0] rsp_frame_count,
   input logic [5:0] rsp_frame_index,
   input logic [15:0] rsp_frame_offset,
   input logic [10:0] rsp_frame_size,
   input logic rsp_last_record
);

   // A waiting record keeps its offset, size and index.
   `APFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_offset) && $stable(rsp_frame_size) && $stable(rsp_frame_index))

   // No packet byte is taken while a record is shown.
   `APFP_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // A corrupted-packet record is always the only and last record.
   `APFP_ASSERT_NOW(a_fail_record, clock, reset, rsp_valid && rsp_status, rsp_last_record && rsp_frame_count == 6'd0)

   // Frame records count up to the frame count and flag the final one.
   `APFP_ASSERT_NOW(a_frame_record, clock, reset, rsp_valid && !rsp_status, rsp_frame_index < rsp_frame_count && rsp_last_record == (rsp_frame_index + 6'd1 == rsp_frame_count))

   // After the final record the parser takes bytes again.
   `APFP_ASSERT_NEXT(a_resume, clock, reset, rsp_valid && rsp_ready && rsp_last_record, req_ready)

endmodule

bind audio_packet_frame_parser_top apfp_checker u_apfp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status),
   .rsp_frame_count(rsp_ch.frame_count),
   .rsp_frame_index(rsp_ch.frame_index),
   .rsp_frame_offset(rsp_ch.frame_offset),
   .rsp_frame_size(rsp_ch.frame_size),
   .rsp_last_record(rsp_ch.last_record)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import apfp_pkg::*;

   localparam int unsigned FRAME_LIMIT = 48;
   localparam int unsigned SAMPLE_RATE = 48000;
   localparam int unsigned SAMPLE_LIMIT = 5760;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 200;

   typedef struct packed {
      logic status;
      logic [BYTE_W-1:0] toc;
      logic [CNT_W-1:0] frame_count;
      logic [CNT_W-1:0] frame_index;
      logic [LEN_W-1:0] frame_offset;
      logic [SIZE_W-1:0] frame_size;
      logic [LEN_W-1:0] header_len;
      logic last_record;
   } frame_rec_t;

   logic clock;
   logic reset;

   apfp_req_if req_bus ();
   apfp_rsp_if rsp_bus ();

   audio_packet_frame_parser_top DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   // Parser state mirrored from the byte stream.
   phase_type pp_phase;
   logic [BYTE_W-1:0] pp_toc;
   logic [BYTE_W-1:0] pp_size_lo;
   int unsigned pp_frames;
   int unsigned pp_remaining;
   int unsigned pp_size_sum;
   int unsigned pp_padding;
   int unsigned pp_hdr;
   int unsigned pp_size_idx;
   int unsigned pp_sizes [FRAME_LIMIT];

   frame_rec_t expected_frames [$];
   logic [BYTE_W-1:0] pkt_bytes [$];
   int unsigned pkt_len;
   int unsigned bytes_parsed;
   int unsigned mismatches;
   int unsigned hold_cycles;
   int unsigned cycle_count;
   bit sender_idling;
   bit receiver_idling;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned frame_samples(input logic [BYTE_W-1:0] t);
      int unsigned span;
      span = t[4:3];
      if (t[7])
         return (SAMPLE_RATE << span) / 400;
      if (t[6:5] == 2'b11)
         return t[3] ? SAMPLE_RATE / 50 : SAMPLE_RATE / 100;
      if (span == 3)
         return SAMPLE_RATE * 60 / 1000;
      return (SAMPLE_RATE << span) / 100;
   endfunction

   function automatic void clear_parser_model();
      pp_phase = PH_IDLE;
      pp_toc = '0;
      pp_size_lo = '0;
      pp_frames = 0;
      pp_remaining = 0;
      pp_size_sum = 0;
      pp_padding = 0;
      pp_hdr = 0;
      pp_size_idx = 0;
      foreach (pp_sizes[i]) pp_sizes[i] = 0;
   endfunction

   function automatic void push_corrupt();
      frame_rec_t r;
      r = '0;
      r.status = 1'b1;
      r.toc = pp_toc;
      r.last_record = 1'b1;
      expected_frames.push_back(r);
      pp_phase = PH_IDLE;
   endfunction

   function automatic void emit_frames(input int unsigned last_size);
      frame_rec_t r;
      int unsigned n;
      int unsigned off;
      int unsigned sz;
      n = pp_frames;
      off = pp_hdr;
      if (last_size > MAX_FRAME_BYTES || n == 0 || n > FRAME_LIMIT) begin
         push_corrupt();
         return;
      end
      pp_sizes[n-1] = last_size;
      for (int unsigned i = 0; i < n; i++) begin
         sz = pp_sizes[i] & 32'h7FF;
         r.status = 1'b0;
         r.toc = pp_toc;
         r.frame_count = n[CNT_W-1:0];
         r.frame_index = i[CNT_W-1:0];
         r.frame_offset = off[LEN_W-1:0];
         r.frame_size = sz[SIZE_W-1:0];
         r.header_len = pp_hdr[LEN_W-1:0];
         r.last_record = (i == n - 1);
         expected_frames.push_back(r);
         off = (off + sz) & 32'h1FFFF;
      end
      pp_phase = PH_IDLE;
   endfunction

   function automatic int unsigned payload_avail();
      return pp_remaining >= pp_padding ? pp_remaining - pp_padding : 0;
   endfunction

   function automatic void close_padding();
      int unsigned avail;
      int unsigned even_size;
      if (pp_padding > pp_remaining) begin
         push_corrupt();
         return;
      end
      avail = pp_remaining - pp_padding;
      if (pp_size_lo[VBR_FLAG_BIT]) begin
         if (pp_frames == 1) begin
            emit_frames(avail);
            return;
         end
         pp_size_idx = 0;
         pp_size_sum = 0;
         pp_phase = PH_C3_LO;
         if (avail == 0) push_corrupt();
         return;
      end
      even_size = avail / pp_frames;
      if (even_size * pp_frames != avail || even_size > MAX_FRAME_BYTES) begin
         push_corrupt();
         return;
      end
      for (int unsigned i = 0; i + 1 < pp_frames; i++) pp_sizes[i] = even_size;
      emit_frames(even_size);
   endfunction

   function automatic void take_coded_size(input int unsigned sz);
      int unsigned avail;
      avail = payload_avail();
      if (sz > avail || pp_size_idx >= FRAME_LIMIT) begin
         push_corrupt();
         return;
      end
      pp_sizes[pp_size_idx] = sz & 32'h7FF;
      pp_size_sum = (pp_size_sum + sz) & 32'h1FFFF;
      pp_size_idx++;
      if (pp_size_idx + 1 >= pp_frames) begin
         if (pp_size_sum > avail) push_corrupt();
         else emit_frames(avail - pp_size_sum);
         return;
      end
      pp_phase = PH_C3_LO;
      if (avail == 0) push_corrupt();
   endfunction

   // Returns 1 when the byte takes part in parsing, 0 when the parser drops it.
   function automatic bit parse_packet_byte(input logic [BYTE_W-1:0] b, input logic st,
                                            input logic [LEN_W-1:0] len);
      int unsigned cnt;
      if (st) begin
         pp_toc = b;
         pp_hdr = 1;
         pp_padding = 0;
         pp_size_sum = 0;
         pp_size_idx = 0;
         pp_size_lo = '0;
         pp_frames = 0;
         pp_phase = PH_IDLE;
         if (len == 0) begin
            push_corrupt();
            return 1'b1;
         end
         pp_remaining = len - 1;
         case (b[1:0])
            FC_ONE: begin
               pp_frames = 1;
               emit_frames(pp_remaining);
            end
            FC_TWO_EQUAL: begin
               pp_frames = 2;
               if (pp_remaining[0] || (pp_remaining >> 1) > MAX_FRAME_BYTES) begin
                  push_corrupt();
               end else begin
                  pp_sizes[0] = pp_remaining >> 1;
                  emit_frames(pp_remaining >> 1);
               end
            end
            FC_TWO_CODED: begin
               pp_frames = 2;
               pp_phase = PH_C2_LO;
               if (pp_remaining == 0) push_corrupt();
            end
            default: begin
               pp_phase = PH_C3_COUNT;
               if (pp_remaining == 0) push_corrupt();
            end
         endcase
         return 1'b1;
      end

      if (pp_phase == PH_IDLE || pp_remaining == 0) begin
         pp_phase = PH_IDLE;
         return 1'b0;
      end
      pp_remaining--;
      pp_hdr = (pp_hdr + 1) & 32'hFFFF;

      case (pp_phase)
         PH_C2_LO, PH_C2_HI: begin
            if (pp_phase == PH_C2_LO && b >= SIZE_ESCAPE) begin
               pp_size_lo = b;
               pp_phase = PH_C2_HI;
               if (pp_remaining == 0) push_corrupt();
            end else begin
               cnt = (pp_phase == PH_C2_LO) ? b : 4 * b + pp_size_lo;
               if (cnt > pp_remaining) begin
                  push_corrupt();
               end else begin
                  pp_sizes[0] = cnt;
                  emit_frames(pp_remaining - cnt);
               end
            end
         end
         PH_C3_COUNT: begin
            cnt = b[5:0];
            if (cnt == 0 || cnt > FRAME_LIMIT || frame_samples(pp_toc) * cnt > SAMPLE_LIMIT) begin
               push_corrupt();
            end else begin
               pp_frames = cnt;
               pp_size_lo = b;
               if (b[PAD_FLAG_BIT]) begin
                  pp_phase = PH_C3_PAD;
                  if (pp_remaining == 0) push_corrupt();
               end else begin
                  close_padding();
               end
            end
         end
         PH_C3_PAD: begin
            pp_padding += (b == PAD_CHAIN) ? PAD_CHAIN_BYTES : b;
            if (pp_padding > 32'hFFFF) pp_padding = 32'hFFFF;
            if (b == PAD_CHAIN) begin
               if (pp_remaining == 0) push_corrupt();
            end else begin
               close_padding();
            end
         end
         PH_C3_LO: begin
            if (b >= SIZE_ESCAPE) begin
               pp_size_lo = b;
               pp_phase = PH_C3_HI;
               if (payload_avail() == 0) push_corrupt();
            end else begin
               take_coded_size(b);
            end
         end
         PH_C3_HI: take_coded_size(4 * b + pp_size_lo);
         default: pp_phase = PH_IDLE;
      endcase
      return 1'b1;
   endfunction

   function automatic string rec_text(input frame_rec_t r);
      return $sformatf("st=%0d toc=%02h cnt=%0d idx=%0d off=%0d size=%0d hdr=%0d last=%0d",
                       r.status, r.toc, r.frame_count, r.frame_index, r.frame_offset,
                       r.frame_size, r.header_len, r.last_record);
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] %s", $time, msg);
   endtask

   initial begin : record_checker
      frame_rec_t got;
      frame_rec_t want;
      int unsigned stall_left;
      string diffs;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status = rsp_bus.status;
            got.toc = rsp_bus.toc;
            got.frame_count = rsp_bus.frame_count;
            got.frame_index = rsp_bus.frame_index;
            got.frame_offset = rsp_bus.frame_offset;
            got.frame_size = rsp_bus.frame_size;
            got.header_len = rsp_bus.header_len;
            got.last_record = rsp_bus.last_record;
            if (expected_frames.size() == 0) begin
               report({"unexpected record: ", rec_text(got)});
            end else begin
               want = expected_frames.pop_front();
               diffs = "";
               if (got.status !== want.status) diffs = {diffs, " status"};
               if (got.toc !== want.toc) diffs = {diffs, " toc"};
               if (got.frame_count !== want.frame_count) diffs = {diffs, " frame_count"};
               if (got.frame_index !== want.frame_index) diffs = {diffs, " frame_index"};
               if (got.frame_offset !== want.frame_offset) diffs = {diffs, " frame_offset"};
               if (got.frame_size !== want.frame_size) diffs = {diffs, " frame_size"};
               if (got.header_len !== want.header_len) diffs = {diffs, " header_len"};
               if (got.last_record !== want.last_record) diffs = {diffs, " last_record"};
               if (diffs != "")
                  report({"wrong", diffs, ": got ", rec_text(got), " / want ", rec_text(want)});
            end
         end
         // A long hold-off takes precedence over the short random stalls.
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st,
                            input logic [LEN_W-1:0] len);
      int unsigned gap;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.packet_start <= st;
      req_bus.packet_len <= len;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (parse_packet_byte(b, st, len)) bytes_parsed++;
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void open_packet(input logic [BYTE_W-1:0] toc);
      pkt_bytes.delete();
      pkt_bytes.push_back(toc);
   endfunction

   // Sizes of 252 and up take a second byte: size = 4 * second + first.
   function automatic void add_size(input int unsigned sz);
      int unsigned lo;
      if (sz < SIZE_ESCAPE) begin
         pkt_bytes.push_back(sz[7:0]);
      end else begin
         lo = SIZE_ESCAPE + (sz - SIZE_ESCAPE) % 4;
         pkt_bytes.push_back(lo[7:0]);
         pkt_bytes.push_back(((sz - lo) / 4) & 32'hFF);
      end
   endfunction

   function automatic void add_padding(input int unsigned pad);
      int unsigned chain;
      chain = pad / PAD_CHAIN_BYTES;
      repeat (chain) pkt_bytes.push_back(PAD_CHAIN);
      pkt_bytes.push_back((pad - chain * PAD_CHAIN_BYTES) & 32'hFF);
   endfunction

   function automatic int unsigned random_size();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_FRAME_BYTES)
                                         : $urandom_range(0, 40);
   endfunction

   task automatic send_packet(input int unsigned tail);
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == 0, pkt_len[LEN_W-1:0]);
      repeat (tail) send_byte($urandom_range(0, 255), 1'b0, pkt_len[LEN_W-1:0]);
   endtask

   task automatic random_packet();
      logic [BYTE_W-1:0] toc;
      int unsigned n;
      int unsigned cap;
      int unsigned pad;
      int unsigned sz;
      int unsigned total;
      int unsigned mode;
      int unsigned cut;
      logic vbr;
      logic with_pad;
      toc = $urandom_range(0, 255);
      open_packet(toc);
      total = 0;
      case (toc[1:0])
         FC_ONE: total = random_size();
         FC_TWO_EQUAL: total = 2 * random_size();
         FC_TWO_CODED: begin
            sz = random_size();
            add_size(sz);
            total = sz + random_size();
         end
         default: begin
            cap = SAMPLE_LIMIT / frame_samples(toc);
            if (cap > FRAME_LIMIT) cap = FRAME_LIMIT;
            mode = $urandom_range(0, 9);
            if (mode == 0) n = $urandom_range(0, 63);
            else if (mode == 1) n = cap;
            else n = $urandom_range(1, cap < 5 ? cap : 5);
            vbr = $urandom_range(0, 1);
            with_pad = ($urandom_range(0, 2) == 0);
            pkt_bytes.push_back({vbr, with_pad, n[5:0]});
            if (with_pad) begin
               pad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1500)
                                                 : $urandom_range(0, 300);
               add_padding(pad);
               total = pad;
            end
            if (vbr) begin
               for (int unsigned i = 1; i < n; i++) begin
                  sz = random_size();
                  add_size(sz);
                  total += sz;
               end
               total += random_size();
            end else begin
               total += n * random_size();
            end
         end
      endcase
      pkt_len = pkt_bytes.size() + total;
      // Most packets are well formed; the rest get a wrong length or a cut header.
      mode = $urandom_range(0, 11);
      if (mode == 0) begin
         pkt_len = $urandom_range(0, 65535);
      end else if (mode == 1) begin
         pkt_len = $urandom_range(1, pkt_len);
      end else if (mode == 2 && pkt_bytes.size() > 1) begin
         cut = $urandom_range(1, pkt_bytes.size() - 1);
         repeat (cut) void'(pkt_bytes.pop_back());
      end
      send_packet(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
   endtask

   task automatic run_traffic(input int unsigned target, input bit with_idling);
      int unsigned goal;
      goal = bytes_parsed + target;
      while (bytes_parsed < goal) begin
         sender_idling = with_idling && ($urandom_range(0, 3) != 0);
         receiver_idling = with_idling && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0)
            send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 65535));
         else
            random_packet();
      end
   endtask

   task automatic test_code0_and_length();
      send_byte(8'h00, 1'b1, 16'd1);
      send_byte(8'hFC, 1'b1, 16'd1276);
      send_byte(8'h04, 1'b1, 16'd1277);
      send_byte(8'h08, 1'b1, 16'd0);
      send_byte(8'h80, 1'b1, 16'hFFFF);
   endtask

   task automatic test_code1();
      send_byte(8'h01, 1'b1, 16'd5);
      send_byte(8'h41, 1'b1, 16'd2551);
      send_byte(8'hC5, 1'b1, 16'd2553);
      send_byte(8'h01, 1'b1, 16'd1);
   endtask

   task automatic test_code2();
      send_byte(8'h02, 1'b1, 16'd1);
      open_packet(8'h02);
      add_size(3);
      pkt_len = 10;
      send_packet(0);
      open_packet(8'h06);
      add_size(1275);
      pkt_len = 1400;
      send_packet(0);
      open_packet(8'hFE);
      pkt_bytes.push_back(SIZE_ESCAPE);
      pkt_len = 2;
      send_packet(0);
      open_packet(8'h02);
      add_size(9);
      pkt_len = 6;
      send_packet(0);
   endtask

   task automatic test_code3();
      open_packet(8'h83);
      pkt_bytes.push_back(8'h03);
      pkt_len = 11;
      send_packet(0);
      open_packet(8'h8B);
      pkt_bytes.push_back(8'hC3);
      add_padding(256);
      add_size(10);
      add_size(256);
      pkt_len = pkt_bytes.size() + 10 + 256 + 5 + 256;
      send_packet(0);
      open_packet(8'h83);
      pkt_bytes.push_back(8'h82);
      add_size(252);
      pkt_len = pkt_bytes.size() + 252 + 7;
      send_packet(0);
      open_packet(8'h03);
      pkt_bytes.push_back(8'h00);
      pkt_len = 20;
      send_packet(0);
      open_packet(8'h83);
      pkt_bytes.push_back(8'h31);
      pkt_len = 100;
      send_packet(0);
      // Frame durations too long for the requested count, then an uneven equal split.
      open_packet(8'h1B);
      pkt_bytes.push_back(8'h03);
      pkt_len = 40;
      send_packet(0);
      open_packet(8'h63);
      pkt_bytes.push_back(8'h0D);
      pkt_len = 40;
      send_packet(0);
      open_packet(8'h83);
      pkt_bytes.push_back(8'h03);
      pkt_len = 12;
      send_packet(0);
   endtask

   task automatic test_stray_and_restart();
      send_byte(8'hA5, 1'b0, 16'd7);
      send_byte(8'h5A, 1'b0, 16'd9);
      send_byte(8'h03, 1'b1, 16'd20);
      send_byte(8'h82, 1'b0, 16'd20);
      send_byte(8'h00, 1'b1, 16'd3);
   endtask

   // Enough chained padding bytes to push the padding total past its ceiling.
   task automatic test_padding_saturation();
      open_packet(8'h83);
      pkt_bytes.push_back(8'h41);
      repeat (259) pkt_bytes.push_back(PAD_CHAIN);
      pkt_bytes.push_back(8'h00);
      pkt_len = 65535;
      send_packet(0);
   endtask

   task automatic test_random_traffic();
      run_traffic(80, 1'b1);
   endtask

   task automatic test_backpressure();
      receiver_idling = 1'b0;
      sender_idling = 1'b0;
      hold_cycles = 400;
      repeat (6) begin
         open_packet(8'h83);
         pkt_bytes.push_back(8'h08);
         pkt_len = 2 + 8 * 3;
         send_packet(0);
      end
   endtask

   task automatic test_steady_stream();
      run_traffic(30, 1'b0);
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.packet_start <= 1'b0;
      req_bus.packet_len <= '0;
      bytes_parsed = 0;
      mismatches = 0;
      hold_cycles = 0;
      cycle_count = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      clear_parser_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_code0_and_length();
      test_code1();
      test_code2();
      test_code3();
      test_stray_and_restart();
      test_padding_saturation();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();

      stop_sending();
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/apfp_pkg.sv
hdl/apfp_if.sv
hdl/apfp_ram.sv
hdl/apfp_div.sv
hdl/audio_packet_frame_parser_top.sv
hdl/apfp_checker.sv
bench/tb_top.sv
